@@ rtl/i2c_register_access_master_unit_macros.svh @@
`ifndef I2C_REGISTER_ACCESS_MASTER_UNIT_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_UNIT_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define I2CRAM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define I2CRAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/i2cram_pkg.sv @@
package i2cram_pkg;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 1'b1;

    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd93;
    localparam logic [7:0] PHASE_TICKS_RST    = 8'd10;

    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    typedef enum logic [4:0] {
        SEQ_IDLE,
        SEQ_START_HI,
        SEQ_START_SDA,
        SEQ_START_LOW,
        SEQ_TX_BIT_LOW,
        SEQ_TX_BIT_HIGH,
        SEQ_TX_ACK_LOW,
        SEQ_TX_ACK_HIGH,
        SEQ_RESTART_PREP,
        SEQ_RESTART_HI,
        SEQ_RESTART_SDA,
        SEQ_RESTART_LOW,
        SEQ_RX_LOW,
        SEQ_RX_HIGH,
        SEQ_MACK_SET,
        SEQ_MACK_HIGH,
        SEQ_MACK_LOW,
        SEQ_STOP_A,
        SEQ_STOP_B,
        SEQ_STOP_C
    } seq_state_t;

    typedef enum logic [1:0] {
        TX_DEVICE_WRITE,
        TX_ADDR_HIGH,
        TX_ADDR_LOW,
        TX_FINAL
    } tx_stage_t;

    typedef struct packed {
        logic        func;
        logic        is_read;
        logic [15:0] reg_address;
        logic [7:0]  write_byte;
        logic [7:0]  byte_count;
        logic        sda_sample;
    } cmd_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic [7:0] read_byte;
        logic       byte_valid;
        logic       last_byte;
        logic       done_res;
        logic       nack_error;
        logic       busy_res;
    } res_t;

endpackage

@@ rtl/i2cram_in.sv @@
module i2cram_in (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  i2cram_pkg::cmd_t   s_cmd,
    input  logic               take,
    output logic               item_valid,
    output i2cram_pkg::cmd_t   item
);

    logic             valid_reg;
    logic             valid_next;
    i2cram_pkg::cmd_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_cmd;
        end
    end

endmodule

@@ rtl/i2cram_seq.sv @@
`include "i2c_register_access_master_unit_macros.svh"

module i2cram_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [i2cram_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cram_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                item_valid,
    input  i2cram_pkg::cmd_t                    item,
    input  logic                                out_ready,
    output logic                                step,
    output i2cram_pkg::res_t                    res
);

    logic [6:0] device_address_reg;
    logic [7:0] phase_ticks_reg;

    i2cram_pkg::seq_state_t state_reg, state_next;
    i2cram_pkg::tx_stage_t  stage_reg, stage_next;
    logic [7:0]  phase_cnt_reg, phase_cnt_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] address_reg, address_next;
    logic [7:0]  wbyte_reg, wbyte_next;
    logic        is_read_reg, is_read_next;

    logic [7:0] limit;
    logic [7:0] cnt_inc;
    logic       tick;
    logic       phase_end;
    logic       last_rd;
    logic       bit_wrap;
    logic [7:0] rx_byte;

    assign step      = item_valid && out_ready;
    assign limit     = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
    assign cnt_inc   = phase_cnt_reg + 8'd1;
    assign tick      = step && !item.func && (state_reg != i2cram_pkg::SEQ_IDLE);
    assign phase_end = tick && (cnt_inc >= limit);
    assign last_rd   = bytes_left_reg <= 8'd1;
    assign bit_wrap  = &bit_cnt_reg;
    assign rx_byte   = {shift_reg[6:0], item.sda_sample};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= i2cram_pkg::DEVICE_ADDRESS_RST;
            phase_ticks_reg    <= i2cram_pkg::PHASE_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                i2cram_pkg::CFG_DEVICE_ADDRESS: device_address_reg <= cfg_wdata[6:0];
                i2cram_pkg::CFG_PHASE_TICKS:    phase_ticks_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        stage_next      = stage_reg;
        phase_cnt_next  = phase_cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        bytes_left_next = bytes_left_reg;
        shift_next      = shift_reg;
        address_next    = address_reg;
        wbyte_next      = wbyte_reg;
        is_read_next    = is_read_reg;
        if (step && item.func && (state_reg == i2cram_pkg::SEQ_IDLE)) begin
            is_read_next    = item.is_read;
            address_next    = item.reg_address;
            wbyte_next      = item.write_byte;
            bytes_left_next = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
            bit_cnt_next    = 3'd0;
            shift_next      = 8'd0;
            phase_cnt_next  = 8'd0;
            state_next      = i2cram_pkg::SEQ_START_HI;
        end else if (tick) begin
            phase_cnt_next = cnt_inc;
            if (phase_end) begin
                phase_cnt_next = 8'd0;
                unique case (state_reg)
                    i2cram_pkg::SEQ_TX_BIT_LOW:   state_next = i2cram_pkg::SEQ_TX_BIT_HIGH;
                    i2cram_pkg::SEQ_TX_BIT_HIGH: begin
                        shift_next   = {shift_reg[6:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        state_next   = bit_wrap ? i2cram_pkg::SEQ_TX_ACK_LOW
                                                : i2cram_pkg::SEQ_TX_BIT_LOW;
                    end
                    i2cram_pkg::SEQ_TX_ACK_LOW:   state_next = i2cram_pkg::SEQ_TX_ACK_HIGH;
                    i2cram_pkg::SEQ_TX_ACK_HIGH: begin
                        priority if (item.sda_sample) begin
                            state_next = i2cram_pkg::SEQ_STOP_A;
                        end else begin
                            unique case (stage_reg)
                                i2cram_pkg::TX_DEVICE_WRITE: begin
                                    state_next   = i2cram_pkg::SEQ_TX_BIT_LOW;
                                    stage_next   = i2cram_pkg::TX_ADDR_HIGH;
                                    shift_next   = address_reg[15:8];
                                    bit_cnt_next = 3'd0;
                                end
                                i2cram_pkg::TX_ADDR_HIGH: begin
                                    state_next   = i2cram_pkg::SEQ_TX_BIT_LOW;
                                    stage_next   = i2cram_pkg::TX_ADDR_LOW;
                                    shift_next   = address_reg[7:0];
                                    bit_cnt_next = 3'd0;
                                end
                                i2cram_pkg::TX_ADDR_LOW: begin
                                    if (is_read_reg) begin
                                        state_next = i2cram_pkg::SEQ_RESTART_PREP;
                                    end else begin
                                        state_next   = i2cram_pkg::SEQ_TX_BIT_LOW;
                                        stage_next   = i2cram_pkg::TX_FINAL;
                                        shift_next   = wbyte_reg;
                                        bit_cnt_next = 3'd0;
                                    end
                                end
                                i2cram_pkg::TX_FINAL: begin
                                    if (is_read_reg) begin
                                        bit_cnt_next = 3'd0;
                                        shift_next   = 8'd0;
                                        state_next   = i2cram_pkg::SEQ_RX_LOW;
                                    end else begin
                                        state_next = i2cram_pkg::SEQ_STOP_A;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    i2cram_pkg::SEQ_START_HI:  state_next = i2cram_pkg::SEQ_START_SDA;
                    i2cram_pkg::SEQ_START_SDA: state_next = i2cram_pkg::SEQ_START_LOW;
                    i2cram_pkg::SEQ_START_LOW: begin
                        state_next   = i2cram_pkg::SEQ_TX_BIT_LOW;
                        stage_next   = i2cram_pkg::TX_DEVICE_WRITE;
                        shift_next   = {device_address_reg, i2cram_pkg::RW_WRITE};
                        bit_cnt_next = 3'd0;
                    end
                    i2cram_pkg::SEQ_RESTART_PREP: state_next = i2cram_pkg::SEQ_RESTART_HI;
                    i2cram_pkg::SEQ_RESTART_HI:   state_next = i2cram_pkg::SEQ_RESTART_SDA;
                    i2cram_pkg::SEQ_RESTART_SDA:  state_next = i2cram_pkg::SEQ_RESTART_LOW;
                    i2cram_pkg::SEQ_RESTART_LOW: begin
                        state_next   = i2cram_pkg::SEQ_TX_BIT_LOW;
                        stage_next   = i2cram_pkg::TX_FINAL;
                        shift_next   = {device_address_reg, i2cram_pkg::RW_READ};
                        bit_cnt_next = 3'd0;
                    end
                    i2cram_pkg::SEQ_RX_LOW: state_next = i2cram_pkg::SEQ_RX_HIGH;
                    i2cram_pkg::SEQ_RX_HIGH: begin
                        shift_next   = rx_byte;
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        state_next   = bit_wrap ? i2cram_pkg::SEQ_MACK_SET
                                                : i2cram_pkg::SEQ_RX_LOW;
                    end
                    i2cram_pkg::SEQ_MACK_SET:  state_next = i2cram_pkg::SEQ_MACK_HIGH;
                    i2cram_pkg::SEQ_MACK_HIGH: state_next = i2cram_pkg::SEQ_MACK_LOW;
                    i2cram_pkg::SEQ_MACK_LOW: begin
                        if (last_rd) begin
                            bytes_left_next = 8'd0;
                            state_next      = i2cram_pkg::SEQ_STOP_A;
                        end else begin
                            bytes_left_next = bytes_left_reg - 8'd1;
                            shift_next      = 8'd0;
                            bit_cnt_next    = 3'd0;
                            state_next      = i2cram_pkg::SEQ_RX_LOW;
                        end
                    end
                    i2cram_pkg::SEQ_STOP_A: state_next = i2cram_pkg::SEQ_STOP_B;
                    i2cram_pkg::SEQ_STOP_B: state_next = i2cram_pkg::SEQ_STOP_C;
                    i2cram_pkg::SEQ_STOP_C: state_next = i2cram_pkg::SEQ_IDLE;
                    default:                state_next = i2cram_pkg::SEQ_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        res = '0;
        unique case (state_reg)
            i2cram_pkg::SEQ_TX_BIT_LOW: begin
                res.scl_level   = 1'b0;
                res.sda_release = shift_reg[7];
            end
            i2cram_pkg::SEQ_TX_BIT_HIGH: begin
                res.scl_level   = 1'b1;
                res.sda_release = shift_reg[7];
            end
            i2cram_pkg::SEQ_TX_ACK_LOW, i2cram_pkg::SEQ_RX_LOW,
            i2cram_pkg::SEQ_RESTART_PREP: begin
                res.scl_level   = 1'b0;
                res.sda_release = 1'b1;
            end
            i2cram_pkg::SEQ_START_SDA, i2cram_pkg::SEQ_RESTART_SDA,
            i2cram_pkg::SEQ_STOP_B: begin
                res.scl_level   = 1'b1;
                res.sda_release = 1'b0;
            end
            i2cram_pkg::SEQ_START_LOW, i2cram_pkg::SEQ_RESTART_LOW,
            i2cram_pkg::SEQ_STOP_A: begin
                res.scl_level   = 1'b0;
                res.sda_release = 1'b0;
            end
            i2cram_pkg::SEQ_MACK_SET, i2cram_pkg::SEQ_MACK_LOW: begin
                res.scl_level   = 1'b0;
                res.sda_release = last_rd;
            end
            i2cram_pkg::SEQ_MACK_HIGH: begin
                res.scl_level   = 1'b1;
                res.sda_release = last_rd;
            end
            default: begin
                res.scl_level   = 1'b1;
                res.sda_release = 1'b1;
            end
        endcase
        if (phase_end && (state_reg == i2cram_pkg::SEQ_RX_HIGH) && bit_wrap) begin
            res.byte_valid = 1'b1;
            res.read_byte  = rx_byte;
            res.last_byte  = last_rd;
        end
        res.done_res   = phase_end && (state_reg == i2cram_pkg::SEQ_STOP_C);
        res.nack_error = phase_end && (state_reg == i2cram_pkg::SEQ_TX_ACK_HIGH)
                         && item.sda_sample;
        res.busy_res   = state_next != i2cram_pkg::SEQ_IDLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= i2cram_pkg::SEQ_IDLE;
            stage_reg      <= i2cram_pkg::TX_DEVICE_WRITE;
            phase_cnt_reg  <= 8'd0;
            bit_cnt_reg    <= 3'd0;
            bytes_left_reg <= 8'd0;
            shift_reg      <= 8'd0;
            address_reg    <= 16'd0;
            wbyte_reg      <= 8'd0;
            is_read_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            stage_reg      <= stage_next;
            phase_cnt_reg  <= phase_cnt_next;
            bit_cnt_reg    <= bit_cnt_next;
            bytes_left_reg <= bytes_left_next;
            shift_reg      <= shift_next;
            address_reg    <= address_next;
            wbyte_reg      <= wbyte_next;
            is_read_reg    <= is_read_next;
        end
    end

    `I2CRAM_ASSERT_NOW(a_byte_while_busy, step && res.byte_valid, res.busy_res, "read byte outside a transaction")
    `I2CRAM_ASSERT_NOW(a_nack_not_done, step, !(res.nack_error && res.done_res), "abort and stop end in one tick")
    `I2CRAM_ASSERT_NOW(a_idle_count_clear, state_reg == i2cram_pkg::SEQ_IDLE, phase_cnt_reg == 8'd0, "phase count left over in idle")
    `I2CRAM_ASSERT_NEXT(a_done_to_idle, step && res.done_res, state_reg == i2cram_pkg::SEQ_IDLE, "stop end did not return to idle")

endmodule

@@ rtl/i2cram_out.sv @@
module i2cram_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  i2cram_pkg::res_t   push_res,
    output logic               push_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output i2cram_pkg::res_t   m_res
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    i2cram_pkg::res_t main_reg, main_next;
    i2cram_pkg::res_t skid_reg, skid_next;
    logic             pop;

    assign pop        = main_valid_reg && m_ready;
    assign push_ready = !skid_valid_reg;
    assign m_valid    = main_valid_reg;
    assign m_res      = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        priority if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_res;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

@@ rtl/i2c_register_access_master_unit.sv @@
// I2C master for devices with 16-bit register addresses. Each request on the s_ side is either
// one tick of the bus time base (tuser 0) or a transaction command (tuser 1), and every request
// yields exactly one result on the m_ side carrying the SCL/SDA levels for that tick, any
// received byte and the done, NACK and busy flags. A request passes an input register, the
// combinational sequencer logic and a two-entry result buffer, and its result is valid on the
// m_ side once the buffer holds it; the step waits while the buffer is full. One request is
// taken every cycle while m_tready stays high; the combinational sequencer step between those
// registers allows that rate. A command arriving mid-transaction is ignored but still
// answered. Write device_address and phase_ticks only while no transaction is running.
module i2c_register_access_master_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [i2cram_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cram_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // is_read, reg_address, write_byte, byte_count, sda_sample, zero pad
    input  logic [i2cram_pkg::S_TDATA_W-1:0]    s_tdata,
    // func
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // scl_level, sda_release, read_byte, done_res, nack_error, busy_res, zero pad
    output logic [i2cram_pkg::M_TDATA_W-1:0]    m_tdata,
    // byte_valid
    output logic                                m_tuser,
    output logic                                m_tlast
);

    i2cram_pkg::cmd_t s_cmd;
    i2cram_pkg::cmd_t item;
    i2cram_pkg::res_t step_res;
    i2cram_pkg::res_t m_res;
    logic             item_valid;
    logic             step;
    logic             out_ready;

    always_comb begin
        s_cmd.func        = s_tuser;
        s_cmd.is_read     = s_tdata[0];
        s_cmd.reg_address = s_tdata[16:1];
        s_cmd.write_byte  = s_tdata[24:17];
        s_cmd.byte_count  = s_tdata[32:25];
        s_cmd.sda_sample  = s_tdata[33];
    end

    i2cram_in u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_cmd      (s_cmd),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cram_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .step       (step),
        .res        (step_res)
    );

    i2cram_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (step),
        .push_res   (step_res),
        .push_ready (out_ready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (m_res)
    );

    assign m_tdata = {3'b000, m_res.busy_res, m_res.nack_error, m_res.done_res,
                      m_res.read_byte, m_res.sda_release, m_res.scl_level};
    assign m_tuser = m_res.byte_valid;
    assign m_tlast = m_res.last_byte;

endmodule
